@@ rtl/lbsps_pkg.sv @@
// ----------------------------------------------------------------------------
// lbsps_pkg
// Shared types, constants and the build-time band edge table of the
// log-spaced band peak smoother.
// ----------------------------------------------------------------------------
package lbsps_pkg;

  localparam int BAND_COUNT    = 64;
  localparam int SPECTRUM_SIZE = 1024;
  localparam int EDGE_OCTAVES  = 10;
  localparam int LOG_FRAC      = 30;

  localparam int MAG_W = 16;
  localparam int TOT_W = 40;
  localparam int IDX_W = $clog2(BAND_COUNT);
  localparam int CB_W  = $clog2(BAND_COUNT + 1);
  localparam int BIN_W = $clog2(SPECTRUM_SIZE);
  localparam int END_W = $clog2(SPECTRUM_SIZE + BAND_COUNT);

  localparam logic [MAG_W-1:0] COEF_RESET = 16'd58982;
  localparam logic [TOT_W-1:0] TOTAL_MAX  = {TOT_W{1'b1}};

  typedef logic [BAND_COUNT-1:0][END_W-1:0] band_end_t;

  typedef struct packed {
    logic [MAG_W-1:0] smoothed;
    logic [TOT_W-1:0] peak_sum;
    logic [TOT_W-1:0] smoothed_sum;
  } band_store_t;

  // log2 with LOG_FRAC fractional bits, m >= 1
  function automatic logic [63:0] log2_fixed(input logic [31:0] m);
    logic [63:0] y;
    logic [63:0] frac;
    logic [5:0]  n;
    n    = '0;
    frac = '0;
    for (int i = 0; i < 31; i++) begin
      if ((m >> (i + 1)) != 32'd0) n = 6'(i + 1);
    end
    y = ({32'd0, m} << 31) >> n;
    for (int i = 1; i <= LOG_FRAC; i++) begin
      y = (y * y) >> 31;
      if (y >= 64'h1_0000_0000) begin
        y    = y >> 1;
        frac = frac | (64'd1 << (LOG_FRAC - i));
      end
    end
    return (64'(n) << LOG_FRAC) | frac;
  endfunction

  function automatic band_end_t build_band_ends();
    band_end_t   ends;
    logic [63:0] q;
    logic [63:0] lim;
    logic [63:0] top;
    logic [63:0] m;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] b0;
    logic [63:0] b1;
    q    = 64'(BAND_COUNT - 1);
    top  = 64'(SPECTRUM_SIZE - 1);
    m    = 64'd1;
    b0   = '0;
    ends = '0;
    for (int x = 0; x < BAND_COUNT; x++) begin
      lim = (64'(x) * 64'(EDGE_OCTAVES)) << LOG_FRAC;
      lo  = m;
      hi  = top;
      for (int k = 0; k < 20; k++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          if (log2_fixed(32'(mid)) * q <= lim) lo = mid;
          else hi = mid - 64'd1;
        end
      end
      if (lo > m) m = lo;
      b1 = m;
      if (b1 <= b0) b1 = b0 + 64'd1;
      ends[x] = END_W'(b1);
      b0 = b1;
    end
    return ends;
  endfunction

  localparam band_end_t BAND_END = build_band_ends();

  function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                               input logic [TOT_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOT_W] ? TOTAL_MAX : s[TOT_W-1:0];
  endfunction

endpackage

@@ rtl/log_band_spectrum_peak_smoother_core.sv @@
// ----------------------------------------------------------------------------
// log_band_spectrum_peak_smoother_core
// Streams spectrum bins, tracks the peak of each log-spaced band and, as a
// band closes, emits its peak, smoothed peak and saturating totals.
// ----------------------------------------------------------------------------
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+-----------------------------------
//  in      | in_valid_i  | in_ready_o  | magnitude_i
//  cfg     | cfg_valid_i | cfg_ready_o | cfg_data_i (smoothing coefficient)
//  out     | out_valid_o | out_ready_i | band_index_o .. last_band_o
//
//  one bin per cycle unless stalled or flushing; a band result passes stages
//  1-3 and the output register; the last bin of a frame holds the input while
//  each band still open (up to 63) is flushed with peak 0 through the same pipeline
//  per-band stores sit in a 64-entry memory with one read and one write port;
//  a valid bit per entry, cleared by reset, makes unwritten bands read as zero
//  every stage holds under output stall and frees as soon as it is empty
// ----------------------------------------------------------------------------
module log_band_spectrum_peak_smoother_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lbsps_pkg::MAG_W-1:0]   magnitude_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lbsps_pkg::MAG_W-1:0]   cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lbsps_pkg::IDX_W-1:0]   band_index_o,
  output logic [lbsps_pkg::MAG_W-1:0]   band_peak_o,
  output logic [lbsps_pkg::MAG_W-1:0]   band_smoothed_o,
  output logic [lbsps_pkg::TOT_W-1:0]   peak_total_o,
  output logic [lbsps_pkg::TOT_W-1:0]   smoothed_total_o,
  output logic                          last_band_o
);
  import lbsps_pkg::*;

  // control and configuration
  logic [MAG_W-1:0] coef_q;
  logic [BIN_W-1:0] bin_q, bin_d;
  logic [CB_W-1:0]  cb_q, cb_d;
  logic [MAG_W-1:0] peak_q, peak_d;
  logic             flush_q, flush_d;

  // stage enables
  logic en_out, en3, en2, en1;

  // front end
  logic             in_acc, is_last, band_open, in_close, issue;
  logic [MAG_W-1:0] peak_new, issue_peak;

  // band store
  band_store_t     mem_q [BAND_COUNT];
  logic [BAND_COUNT-1:0] vld_q;
  band_store_t     rd_q;
  logic            rdv_q;
  logic            wr_en;

  // stage 1
  logic             s1_vld_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic [MAG_W-1:0] s1_peak_q;
  logic [MAG_W-1:0] s1_old;
  logic [TOT_W-1:0] s1_psum, s1_ssum, s1_psum_new;
  logic signed [MAG_W:0]     s1_diff, s1_coef;
  logic signed [2*MAG_W+1:0] s1_prod;

  // stage 2
  logic                      s2_vld_q;
  logic [IDX_W-1:0]          s2_idx_q;
  logic [MAG_W-1:0]          s2_peak_q;
  logic signed [2*MAG_W+1:0] s2_prod_q;
  logic [TOT_W-1:0]          s2_psum_q, s2_ssum_q;
  logic signed [2*MAG_W+1:0] s2_acc;

  // stage 3
  logic             s3_vld_q;
  logic [IDX_W-1:0] s3_idx_q;
  logic [MAG_W-1:0] s3_peak_q, s3_smooth_q;
  logic [TOT_W-1:0] s3_psum_q, s3_ssum_q, s3_ssum_new;

  // output register
  logic             out_vld_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [MAG_W-1:0] out_peak_q, out_smooth_q;
  logic [TOT_W-1:0] out_psum_q, out_ssum_q;

  assign en_out = !out_vld_q || out_ready_i;
  assign en3    = !s3_vld_q || en_out;
  assign en2    = !s2_vld_q || en3;
  assign en1    = !s1_vld_q || en2;

  assign in_ready_o  = en1 && !flush_q;
  assign cfg_ready_o = 1'b1;

  assign in_acc    = in_valid_i && in_ready_o;
  assign is_last   = (bin_q == BIN_W'(SPECTRUM_SIZE - 1));
  assign band_open = (cb_q < CB_W'(BAND_COUNT));
  assign peak_new  = (magnitude_i > peak_q) ? magnitude_i : peak_q;
  assign in_close  = in_acc && (bin_q != '0) && band_open &&
                     ({{(END_W-BIN_W){1'b0}}, bin_q} >= BAND_END[cb_q[IDX_W-1:0]]);
  assign issue      = in_close || (flush_q && en1);
  assign issue_peak = in_close ? peak_new : '0;

  always_comb begin
    cb_d    = cb_q;
    peak_d  = peak_q;
    bin_d   = bin_q;
    flush_d = flush_q;
    if (in_acc) begin
      if (bin_q == '0) begin
        peak_d = '0;
        cb_d   = '0;
      end else if (band_open) begin
        peak_d = in_close ? '0 : peak_new;
        cb_d   = cb_q + CB_W'(in_close);
      end
      if (is_last) begin
        bin_d  = '0;
        peak_d = '0;
        if (cb_d < CB_W'(BAND_COUNT)) begin
          flush_d = 1'b1;
        end else begin
          cb_d = '0;
        end
      end else begin
        bin_d = bin_q + BIN_W'(1);
      end
    end else if (flush_q && en1) begin
      if (cb_q == CB_W'(BAND_COUNT - 1)) begin
        flush_d = 1'b0;
        cb_d    = '0;
      end else begin
        cb_d = cb_q + CB_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q  <= COEF_RESET;
      bin_q   <= '0;
      cb_q    <= '0;
      peak_q  <= '0;
      flush_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) coef_q <= cfg_data_i;
      bin_q   <= bin_d;
      cb_q    <= cb_d;
      peak_q  <= peak_d;
      flush_q <= flush_d;
    end
  end

  // band store: read at issue, write back as the result is registered
  assign wr_en = en_out && s3_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[s3_idx_q] <= '{smoothed: s3_smooth_q, peak_sum: s3_psum_q,
                                    smoothed_sum: s3_ssum_new};
    if (en1) begin
      rd_q  <= mem_q[cb_q[IDX_W-1:0]];
      rdv_q <= vld_q[cb_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[s3_idx_q] <= 1'b1;
    end
  end

  // stage 1: difference product and peak total
  assign s1_old      = rdv_q ? rd_q.smoothed : '0;
  assign s1_psum     = rdv_q ? rd_q.peak_sum : '0;
  assign s1_ssum     = rdv_q ? rd_q.smoothed_sum : '0;
  assign s1_coef     = signed'({1'b0, coef_q});
  assign s1_diff     = signed'({1'b0, s1_old}) - signed'({1'b0, s1_peak_q});
  assign s1_prod     = s1_coef * s1_diff;
  assign s1_psum_new = sat_add(s1_psum, TOT_W'(s1_peak_q));

  // stage 2: peak plus weighted difference, rounded
  assign s2_acc = signed'({2'b00, s2_peak_q, {MAG_W{1'b0}}}) + s2_prod_q +
                  signed'((2*MAG_W+2)'(32768));

  // stage 3: smoothed total
  assign s3_ssum_new = sat_add(s3_ssum_q, TOT_W'(s3_smooth_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (en1)    s1_vld_q  <= issue;
      if (en2)    s2_vld_q  <= s1_vld_q;
      if (en3)    s3_vld_q  <= s2_vld_q;
      if (en_out) out_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_idx_q  <= cb_q[IDX_W-1:0];
      s1_peak_q <= issue_peak;
    end
    if (en2) begin
      s2_idx_q  <= s1_idx_q;
      s2_peak_q <= s1_peak_q;
      s2_prod_q <= s1_prod;
      s2_psum_q <= s1_psum_new;
      s2_ssum_q <= s1_ssum;
    end
    if (en3) begin
      s3_idx_q    <= s2_idx_q;
      s3_peak_q   <= s2_peak_q;
      s3_smooth_q <= s2_acc[2*MAG_W-1:MAG_W];
      s3_psum_q   <= s2_psum_q;
      s3_ssum_q   <= s2_ssum_q;
    end
    if (en_out) begin
      out_idx_q    <= s3_idx_q;
      out_peak_q   <= s3_peak_q;
      out_smooth_q <= s3_smooth_q;
      out_psum_q   <= s3_psum_q;
      out_ssum_q   <= s3_ssum_new;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign band_index_o     = out_idx_q;
  assign band_peak_o      = out_peak_q;
  assign band_smoothed_o  = out_smooth_q;
  assign peak_total_o     = out_psum_q;
  assign smoothed_total_o = out_ssum_q;
  assign last_band_o      = (out_idx_q == IDX_W'(BAND_COUNT - 1));

  a_flush_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> !in_ready_o)
    else $error("input accepted during band flush");

  a_flush_band_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> (cb_q < CB_W'(BAND_COUNT)))
    else $error("flush beyond last band");

  a_no_store_hazard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && s2_vld_q) |-> (s1_idx_q != s2_idx_q))
    else $error("same band twice in update pipeline");

  a_total_covers_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (peak_total_o >= TOT_W'(band_peak_o)))
    else $error("peak total below band peak");

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Streams spectrum bins into the log-band peak smoother under random and
// forced backpressure. A scoreboard tracks band edges, running peaks,
// smoothed values and saturating totals, and checks every band result field
// by field against the expected result at the head of its queue.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int BANDS         = lbsps_pkg::BAND_COUNT;
  localparam int BINS          = lbsps_pkg::SPECTRUM_SIZE;
  localparam int OCTAVES       = lbsps_pkg::EDGE_OCTAVES;
  localparam int MAG_W         = lbsps_pkg::MAG_W;
  localparam int TOT_W         = lbsps_pkg::TOT_W;
  localparam int IDX_W         = lbsps_pkg::IDX_W;
  localparam int Q_FRAC        = 30;
  localparam int MAX_PER_BIN   = 64;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int CORNER_COUNT  = 17;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int NO_EVENT      = -1;
  localparam int PHASE_BINS    = 70;
  localparam int HOLD_AT       = 8;
  localparam int PAUSE_AT      = 35;

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [TOT_W-1:0] total_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    mag_t             peak;
    mag_t             smoothed;
    total_t           peak_total;
    total_t           smoothed_total;
    logic             last;
  } band_result_t;

  class band_scoreboard;
    mag_t         coef;
    int unsigned  bin_pos;
    int unsigned  band_pos;
    mag_t         peak_run;
    mag_t         smoothed_mem [BANDS];
    total_t       peak_sum_mem [BANDS];
    total_t       smoothed_sum_mem [BANDS];
    int unsigned  band_last_bin [BANDS];
    band_result_t band_results_due [$];
    int unsigned  failures;
    int unsigned  results_checked;
    int unsigned  bins_taken;

    function new();
      coef            = lbsps_pkg::COEF_RESET;
      bin_pos         = 0;
      band_pos        = 0;
      peak_run        = '0;
      failures        = 0;
      results_checked = 0;
      bins_taken      = 0;
      for (int b = 0; b < BANDS; b++) begin
        smoothed_mem[b]     = '0;
        peak_sum_mem[b]     = '0;
        smoothed_sum_mem[b] = '0;
      end
      build_band_edges();
    endfunction

    // log2 with Q_FRAC fractional bits
    function logic [63:0] log2_q(input int unsigned m);
      int unsigned msb;
      logic [63:0] y;
      logic [63:0] frac;
      msb  = 0;
      frac = '0;
      for (int i = 1; i < 32; i++) if ((m >> i) != 0) msb = i;
      y = (64'(m) << 31) >> msb;
      for (int k = 1; k <= Q_FRAC; k++) begin
        y = (y * y) >> 31;
        if (y >= 64'h1_0000_0000) begin
          y = y >> 1;
          frac[Q_FRAC-k] = 1'b1;
        end
      end
      return (64'(msb) << Q_FRAC) | frac;
    endfunction

    function void build_band_edges();
      int unsigned m;
      int unsigned prev_end;
      int unsigned this_end;
      logic [63:0] lim;
      m        = 1;
      prev_end = 0;
      for (int x = 0; x < BANDS; x++) begin
        lim = (64'(x) * 64'(OCTAVES)) << Q_FRAC;
        while (m < BINS - 1 && log2_q(m + 1) * 64'(BANDS - 1) <= lim) m++;
        this_end = (m <= prev_end) ? prev_end + 1 : m;
        band_last_bin[x] = this_end;
        prev_end = this_end;
      end
    endfunction

    function total_t sat_sum(input total_t a, input total_t b);
      logic [TOT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
    endfunction

    function void close_band(input int unsigned idx, input mag_t pk);
      logic [63:0]  acc;
      band_result_t r;
      acc = 64'(coef) * 64'(smoothed_mem[idx]) + (64'd65536 - 64'(coef)) * 64'(pk)
            + 64'd32768;
      smoothed_mem[idx]     = acc[31:16];
      peak_sum_mem[idx]     = sat_sum(peak_sum_mem[idx], total_t'(pk));
      smoothed_sum_mem[idx] = sat_sum(smoothed_sum_mem[idx], total_t'(smoothed_mem[idx]));
      r.idx            = IDX_W'(idx);
      r.peak           = pk;
      r.smoothed       = smoothed_mem[idx];
      r.peak_total     = peak_sum_mem[idx];
      r.smoothed_total = smoothed_sum_mem[idx];
      r.last           = (idx == BANDS - 1);
      band_results_due.push_back(r);
    endfunction

    function void take_bin(input mag_t mag);
      int n;
      n = 0;
      bins_taken++;
      if (bin_pos == 0) begin
        peak_run = '0;
        band_pos = 0;
      end else begin
        if (band_pos < BANDS) begin
          if (mag > peak_run) peak_run = mag;
          if (bin_pos >= band_last_bin[band_pos]) begin
            close_band(band_pos, peak_run);
            n++;
            band_pos++;
            peak_run = '0;
          end
        end
        if (bin_pos >= BINS - 1) begin
          while (band_pos < BANDS && n < MAX_PER_BIN) begin
            close_band(band_pos, '0);
            n++;
            band_pos++;
          end
        end
      end
      if (bin_pos + 1 >= BINS) begin
        bin_pos  = 0;
        band_pos = 0;
        peak_run = '0;
      end else begin
        bin_pos++;
      end
    endfunction

    function void check_band(input band_result_t got);
      band_result_t want;
      if (band_results_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("band result with nothing pending: idx=%0d peak=%h", got.idx, got.peak);
        return;
      end
      want = band_results_due.pop_front();
      results_checked++;
      if (got.idx !== want.idx || got.peak !== want.peak || got.smoothed !== want.smoothed ||
          got.peak_total !== want.peak_total || got.smoothed_total !== want.smoothed_total ||
          got.last !== want.last) begin
        failures++;
        if (failures <= 10) begin
          $display("band mismatch exp: idx=%0d peak=%h sm=%h ptot=%h stot=%h last=%b",
                   want.idx, want.peak, want.smoothed, want.peak_total,
                   want.smoothed_total, want.last);
          $display("band mismatch got: idx=%0d peak=%h sm=%h ptot=%h stot=%h last=%b",
                   got.idx, got.peak, got.smoothed, got.peak_total,
                   got.smoothed_total, got.last);
        end
      end
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  mag_t               magnitude_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  mag_t               cfg_data_i  = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [IDX_W-1:0]   band_index_o;
  mag_t               band_peak_o;
  mag_t               band_smoothed_o;
  total_t             peak_total_o;
  total_t             smoothed_total_o;
  logic               last_band_o;

  band_scoreboard sb;
  bit             tx_idle_on  = 1'b1;
  bit             rx_idle_on  = 1'b1;
  bit             rx_hold_req = 1'b0;
  int             hold_left   = 0;
  mag_t           rand_coef;

  log_band_spectrum_peak_smoother_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .magnitude_i      (magnitude_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .band_index_o     (band_index_o),
    .band_peak_o      (band_peak_o),
    .band_smoothed_o  (band_smoothed_o),
    .peak_total_o     (peak_total_o),
    .smoothed_total_o (smoothed_total_o),
    .last_band_o      (last_band_o)
  );

  always #5 clk_i = ~clk_i;

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      hold_left   = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(rx_idle_on && $urandom_range(99) < 9);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_band({band_index_o, band_peak_o, band_smoothed_o, peak_total_o,
                     smoothed_total_o, last_band_o});
  end

  function automatic mag_t corner_mag(input int k);
    case (k)
      0:       return 16'hFFFF;
      1:       return 16'h0000;
      2:       return 16'hFFFF;
      3:       return 16'h0001;
      4:       return 16'hFFFE;
      5:       return 16'hAAAA;
      6:       return 16'h5555;
      7:       return 16'h8000;
      8:       return 16'h7FFF;
      9:       return 16'h0000;
      10:      return 16'h0000;
      11:      return 16'hFFFF;
      12:      return 16'hFFFF;
      13:      return 16'h00FF;
      14:      return 16'hFF00;
      15:      return 16'h0002;
      default: return 16'h0003;
    endcase
  endfunction

  function automatic mag_t random_mag();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel <= 3) return mag_t'($urandom_range(255));
    return mag_t'($urandom);
  endfunction

  task automatic send_bin(input mag_t v);
    if (tx_idle_on) begin
      while ($urandom_range(99) < 9) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    magnitude_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_bin(v);
  endtask

  task automatic write_coef(input mag_t c);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.coef = c;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.band_results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_bins(input int count, input bit with_corners, input int hold_at,
                          input int pause_at, input mag_t pause_coef);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) rx_hold_req = 1'b1;
      if (i == pause_at) begin
        settle();
        write_coef(pause_coef);
      end
      if (with_corners && i < CORNER_COUNT) send_bin(corner_mag(i));
      else send_bin(random_mag());
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rand_coef = mag_t'($urandom_range(65534, 1));
    run_bins(PHASE_BINS, 1'b1, HOLD_AT, NO_EVENT, '0);
    settle();
    write_coef('0);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_bins(PHASE_BINS, 1'b0, NO_EVENT, NO_EVENT, '0);
    settle();
    write_coef('1);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_bins(PHASE_BINS, 1'b0, NO_EVENT, PAUSE_AT, rand_coef);
    settle();

    if (sb.band_results_due.size() != 0) begin
      sb.failures++;
      $display("%0d band results never arrived", sb.band_results_due.size());
    end
    $display("covered %0d bins, %0d band results checked",
             sb.bins_taken, sb.results_checked);
    $display("coefficients: reset value, 0, 65535, %0d mid-stream; %0d-cycle output hold",
             rand_coef, HOLD_CYCLES);
    if (sb.failures == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("timeout");
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
